// ----- src/ptpd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the vertex transform pipeline.
// Used by every module of the block; depends on nothing.
package ptpd_pkg;

  localparam int SW   = 66;        // exact row sum, signed
  localparam int MAGW = 65;        // magnitude of a row sum
  localparam int NW   = MAGW + 16; // dividend |S| * 2^16
  localparam int QW   = 33;        // quotient bits kept before saturation
  localparam int CW   = 99;        // room for divisor shifted by up to QW
  localparam int NDW  = MAGW - 16; // magnitude without divide

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic signed [SW-1:0] ONE_Q32 = SW'(64'h1_0000_0000);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               divided;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] sz;
    logic signed [SW-1:0] sw;
  } sum_t;

  typedef struct packed {
    logic [NW-1:0]  rem;
    logic [QW-1:0]  q;
    logic [NDW-1:0] nd;
    logic           neg;
    logic           ovf;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]     lanes;
    logic [MAGW-1:0] den;
    logic            divide;
  } div_t;

  function automatic logic [15:0][31:0] mat_reset();
    logic [15:0][31:0] m;
    m     = '0;
    m[0]  = ONE_Q16;
    m[5]  = ONE_Q16;
    m[10] = ONE_Q16;
    m[15] = ONE_Q16;
    return m;
  endfunction

endpackage

// ----- src/ptpd_mac.sv -----
`timescale 1ns / 1ps
// Request register, matrix storage, product stage and row-sum stage.
// Depends on ptpd_pkg.
module ptpd_mac (
  input  logic            clk,
  input  logic            rst,
  input  logic            pt_valid,
  input  ptpd_pkg::in_t   pt,
  output logic            pt_stall,
  output logic            sum_valid,
  input  logic            sum_ready,
  output ptpd_pkg::sum_t  sum
);

  logic [15:0][31:0]  matrix;
  logic               va;
  ptpd_pkg::in_t      a;
  logic               vb;
  logic signed [63:0] prod [4][3];
  logic signed [63:0] prod_next [4][3];
  logic [3:0][31:0]   trans;
  logic               ready_a;
  logic               ready_b;
  logic               ready_c;
  ptpd_pkg::sum_t     sum_next;

  assign ready_c  = !sum_valid || sum_ready;
  assign ready_b  = !vb || ready_c;
  // a load retires from the request register without going further
  assign ready_a  = !va || (a.op == ptpd_pkg::OP_LOAD) || ready_b;
  assign pt_stall = !ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= pt_valid;
    end
    if (ready_a && pt_valid) begin
      a <= pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= ptpd_pkg::mat_reset();
    end else if (va && a.op == ptpd_pkg::OP_LOAD) begin
      matrix[a.elem_index] <= a.elem_value;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      prod_next[r][0] = $signed(matrix[r])     * a.point_x;
      prod_next[r][1] = $signed(matrix[r + 4]) * a.point_y;
      prod_next[r][2] = $signed(matrix[r + 8]) * a.point_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va && (a.op == ptpd_pkg::OP_XFORM);
    end
    if (ready_b) begin
      prod <= prod_next;
      for (int r = 0; r < 4; r++) begin
        trans[r] <= matrix[r + 12];
      end
    end
  end

  function automatic logic signed [ptpd_pkg::SW-1:0] row(
    input logic signed [63:0] p0,
    input logic signed [63:0] p1,
    input logic signed [63:0] p2,
    input logic [31:0]        t
  );
    logic signed [ptpd_pkg::SW-1:0] tw;
    tw = $signed({{(ptpd_pkg::SW - 48){t[31]}}, t, 16'b0});
    return ptpd_pkg::SW'(p0) + ptpd_pkg::SW'(p1) + ptpd_pkg::SW'(p2) + tw;
  endfunction

  always_comb begin
    sum_next.sx = row(prod[0][0], prod[0][1], prod[0][2], trans[0]);
    sum_next.sy = row(prod[1][0], prod[1][1], prod[1][2], trans[1]);
    sum_next.sz = row(prod[2][0], prod[2][1], prod[2][2], trans[2]);
    sum_next.sw = row(prod[3][0], prod[3][1], prod[3][2], trans[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (ready_c) begin
      sum_valid <= vb;
    end
    if (ready_c && vb) begin
      sum <= sum_next;
    end
  end

endmodule

// ----- src/ptpd_prep.sv -----
`timescale 1ns / 1ps
// Magnitudes, divide decision and overflow screen ahead of the divider.
// Depends on ptpd_pkg.
module ptpd_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     tol,
  input  logic            sum_valid,
  output logic            sum_ready,
  input  ptpd_pkg::sum_t  sum,
  output logic            dv_valid,
  input  logic            dv_ready,
  output ptpd_pkg::div_t  dv
);

  typedef struct packed {
    logic [2:0][ptpd_pkg::MAGW-1:0] mag;
    logic [2:0]                     neg;
    logic [ptpd_pkg::MAGW-1:0]      wmag;
    logic                           wneg;
    logic                           divide;
  } prep_t;

  logic                      vd;
  prep_t                     d;
  prep_t                     d_next;
  logic                      ready_d;
  logic                      ready_e;
  ptpd_pkg::div_t            dv_next;
  logic signed [ptpd_pkg::SW-1:0] wm1;
  logic [ptpd_pkg::MAGW-1:0] wm1_mag;
  logic [ptpd_pkg::MAGW-1:0] tol_q32;
  logic [ptpd_pkg::CW-1:0]   den_top;

  function automatic logic [ptpd_pkg::MAGW-1:0] mag_of(
    input logic signed [ptpd_pkg::SW-1:0] v
  );
    return v[ptpd_pkg::SW-1] ? ptpd_pkg::MAGW'(-v) : ptpd_pkg::MAGW'(v);
  endfunction

  assign ready_e   = !dv_valid || dv_ready;
  assign ready_d   = !vd || ready_e;
  assign sum_ready = ready_d;

  always_comb begin
    tol_q32       = ptpd_pkg::MAGW'({tol, 16'b0});
    wm1           = sum.sw - ptpd_pkg::ONE_Q32;
    wm1_mag       = mag_of(wm1);
    d_next.mag[0] = mag_of(sum.sx);
    d_next.mag[1] = mag_of(sum.sy);
    d_next.mag[2] = mag_of(sum.sz);
    d_next.neg[0] = sum.sx[ptpd_pkg::SW-1];
    d_next.neg[1] = sum.sy[ptpd_pkg::SW-1];
    d_next.neg[2] = sum.sz[ptpd_pkg::SW-1];
    d_next.wmag   = mag_of(sum.sw);
    d_next.wneg   = sum.sw[ptpd_pkg::SW-1];
    d_next.divide = (d_next.wmag > tol_q32) && (wm1_mag > tol_q32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (ready_d) begin
      vd <= sum_valid;
    end
    if (ready_d && sum_valid) begin
      d <= d_next;
    end
  end

  always_comb begin
    den_top        = ptpd_pkg::CW'(d.wmag) << ptpd_pkg::QW;
    dv_next.den    = d.wmag;
    dv_next.divide = d.divide;
    for (int l = 0; l < 3; l++) begin
      dv_next.lanes[l].rem = {d.mag[l], 16'b0};
      dv_next.lanes[l].q   = '0;
      dv_next.lanes[l].nd  = d.mag[l][ptpd_pkg::MAGW-1:16];
      dv_next.lanes[l].neg = d.divide ? (d.neg[l] ^ d.wneg) : d.neg[l];
      // quotient would need more than QW bits: clamp at the end
      dv_next.lanes[l].ovf = d.divide &&
                             (ptpd_pkg::CW'({d.mag[l], 16'b0}) >= den_top);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= 1'b0;
    end else if (ready_e) begin
      dv_valid <= vd;
    end
    if (ready_e && vd) begin
      dv <= dv_next;
    end
  end

endmodule

// ----- src/ptpd_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage for three lanes at once.
// Depends on ptpd_pkg.
module ptpd_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            dv_valid,
  output logic            dv_ready,
  input  ptpd_pkg::div_t  dv,
  output logic            q_valid,
  input  logic            q_ready,
  output ptpd_pkg::div_t  q
);

  logic [ptpd_pkg::QW:0]   v;
  logic [ptpd_pkg::QW+1:1] rdy;
  ptpd_pkg::div_t          d [ptpd_pkg::QW+1];

  assign v[0]                = dv_valid;
  assign d[0]                = dv;
  assign rdy[ptpd_pkg::QW+1] = q_ready;
  assign dv_ready            = rdy[1];
  assign q_valid             = v[ptpd_pkg::QW];
  assign q                   = d[ptpd_pkg::QW];

  for (genvar k = 1; k <= ptpd_pkg::QW; k++) begin : g_stage
    ptpd_pkg::div_t d_next;
    logic           vr;
    ptpd_pkg::div_t dr;

    assign v[k]   = vr;
    assign d[k]   = dr;
    assign rdy[k] = !v[k] || rdy[k+1];

    always_comb begin
      logic [ptpd_pkg::CW-1:0] den_sh;
      logic [ptpd_pkg::CW-1:0] rem_w;
      logic                    ge;
      d_next = d[k-1];
      den_sh = ptpd_pkg::CW'(d[k-1].den) << (ptpd_pkg::QW - k);
      for (int l = 0; l < 3; l++) begin
        rem_w = ptpd_pkg::CW'(d[k-1].lanes[l].rem);
        ge    = rem_w >= den_sh;
        if (ge) begin
          d_next.lanes[l].rem = ptpd_pkg::NW'(rem_w - den_sh);
          d_next.lanes[l].q[ptpd_pkg::QW - k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr <= 1'b0;
      end else if (rdy[k]) begin
        vr <= v[k-1];
      end
      if (rdy[k] && v[k-1]) begin
        dr <= d_next;
      end
    end
  end

endmodule

// ----- src/point_transform_perspective_divide_top.sv -----
`timescale 1ns / 1ps
// Top level of the Q16.16 vertex transform: tolerance register, pipeline, result stage.
// Depends on ptpd_pkg, ptpd_mac, ptpd_prep and ptpd_div.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   request  | pt_valid / pt_stall  | pt  (ptpd_pkg::in_t)
//   result   | res_valid / res_stall| res (ptpd_pkg::out_t)
//   config   | cfg_valid / cfg_ready| cfg_data (w_tolerance)
//
// One request enters per cycle while pt_stall is low; a transform's result passes through
// 39 register stages (request, products, sums, prep, screen, 33 divider stages,
// result), and a load updates the matrix from the request register and produces nothing.
// The 33-stage divider sets the latency. Reset restores the identity matrix and
// a zero tolerance. Each stage holds while the one after it is full and stalled.
module point_transform_perspective_divide_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            pt_valid,
  output logic            pt_stall,
  input  ptpd_pkg::in_t   pt,
  output logic            res_valid,
  input  logic            res_stall,
  output ptpd_pkg::out_t  res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data
);

  logic [15:0]    tol;
  logic           sum_valid;
  logic           sum_ready;
  ptpd_pkg::sum_t sum;
  logic           dv_valid;
  logic           dv_ready;
  ptpd_pkg::div_t dv;
  logic           q_valid;
  logic           q_ready;
  ptpd_pkg::div_t q;
  ptpd_pkg::out_t res_next;
  logic [2:0][31:0] coord;
  logic [2:0]     over;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  ptpd_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt        (pt),
    .pt_stall  (pt_stall),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  ptpd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .tol       (tol),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .dv_valid  (dv_valid),
    .dv_ready  (dv_ready),
    .dv        (dv)
  );

  ptpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .dv_valid (dv_valid),
    .dv_ready (dv_ready),
    .dv       (dv),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q        (q)
  );

  assign q_ready = !res_valid || !res_stall;

  always_comb begin
    logic [ptpd_pkg::NDW-1:0] mag;
    logic [ptpd_pkg::NDW-1:0] lim;
    for (int l = 0; l < 3; l++) begin
      mag = q.divide ? ptpd_pkg::NDW'(q.lanes[l].q) : q.lanes[l].nd;
      lim = q.lanes[l].neg ? ptpd_pkg::NDW'(33'h0_8000_0000)
                           : ptpd_pkg::NDW'(33'h0_7FFF_FFFF);
      over[l] = (q.divide && q.lanes[l].ovf) || (mag > lim);
      if (over[l]) begin
        coord[l] = q.lanes[l].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        coord[l] = q.lanes[l].neg ? (~mag[31:0] + 32'd1) : mag[31:0];
      end
    end
    res_next.out_x     = coord[0];
    res_next.out_y     = coord[1];
    res_next.out_z     = coord[2];
    res_next.divided   = q.divide;
    res_next.saturated = |over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_ready) begin
      res_valid <= q_valid;
    end
    if (q_ready && q_valid) begin
      res <= res_next;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the Q16.16 vertex transform: random and directed loads and transforms,
// checked against a behavioral predictor of the matrix, the divide and the saturation.
// Depends on ptpd_pkg and point_transform_perspective_divide_top.
module tb_top;

  localparam int LATENCY = 38;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pt_valid = 1'b0;
  logic pt_stall;
  ptpd_pkg::in_t pt = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  ptpd_pkg::out_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  point_transform_perspective_divide_top DUT (
    .clk(clk), .rst(rst), .pt_valid(pt_valid), .pt_stall(pt_stall), .pt(pt),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic signed [31:0] mat [16];
  logic [15:0] tol_reg;

  ptpd_pkg::in_t pending_req[$];
  ptpd_pkg::out_t expected_pts[$];
  int send_idle_pct = 27, recv_idle_pct = 51;
  bit send_hold = 0;
  bit recv_hold = 0;
  int recv_hold_cycles = 0;
  int mismatches = 0, accepted_pts = 0, checked_pts = 0, loads = 0, divides = 0, sats = 0;
  int idle_cycles = 0;

  function automatic logic signed [31:0] clamp_coord(logic signed [127:0] sum,
      logic signed [127:0] wv, bit dodiv, ref bit sat);
    logic [127:0] mag, wm, q;
    bit neg;
    mag = sum < 0 ? -sum : sum;
    neg = sum < 0;
    if (dodiv) begin
      wm = wv < 0 ? -wv : wv;
      q = (mag << 16) / wm;
      neg = neg ^ (wv < 0);
    end else
      q = mag >> 16;
    if (!neg && q > 128'h7FFF_FFFF) begin
      sat = 1; return 32'h7FFF_FFFF;
    end
    if (neg && q > 128'h8000_0000) begin
      sat = 1; return 32'h8000_0000;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  task automatic apply_request(ptpd_pkg::in_t r);
    logic signed [127:0] s[4], tol, w1, wabs;
    bit dodiv, sat;
    ptpd_pkg::out_t o;
    if (r.op == ptpd_pkg::OP_LOAD) begin
      mat[r.elem_index] = r.elem_value;
      loads++;
      return;
    end
    for (int k = 0; k < 4; k++)
      s[k] = 128'(mat[k]) * 128'(r.point_x) + 128'(mat[k+4]) * 128'(r.point_y)
           + 128'(mat[k+8]) * 128'(r.point_z) + (128'(mat[k+12]) <<< 16);
    tol = 128'(tol_reg) << 16;
    wabs = s[3] < 0 ? -s[3] : s[3];
    w1 = s[3] - (128'sd1 <<< 32);
    if (w1 < 0) w1 = -w1;
    dodiv = wabs > tol && w1 > tol;
    sat = 0;
    o.out_x = clamp_coord(s[0], s[3], dodiv, sat);
    o.out_y = clamp_coord(s[1], s[3], dodiv, sat);
    o.out_z = clamp_coord(s[2], s[3], dodiv, sat);
    o.divided = dodiv;
    o.saturated = sat;
    divides += dodiv;
    sats += sat;
    expected_pts.push_back(o);
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else begin
      if (pt_valid && !pt_stall) begin
        apply_request(pt);
        accepted_pts++;
      end
      if (!pt_valid || !pt_stall) begin
        if (pending_req.size() > 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          pt <= pending_req.pop_front();
          pt_valid <= 1'b1;
        end else begin
          pt_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        checked_pts++;
        if (expected_pts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", res);
        end else begin
          ptpd_pkg::out_t e;
          e = expected_pts.pop_front();
          if (e !== res) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, res);
          end
        end
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        res_stall <= 1'b1;
      end else
        res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst || (pt_valid && !pt_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d requests queued", pending_req.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3: return $signed(32'($urandom_range(8))) <<< 16;
      default: return $signed(32'($urandom_range(200000))) - 100000;
    endcase
  endfunction

  function automatic ptpd_pkg::in_t make_load(int idx, logic signed [31:0] v);
    ptpd_pkg::in_t r;
    r = '0;
    r.op = ptpd_pkg::OP_LOAD;
    r.elem_index = idx[3:0];
    r.elem_value = v;
    r.point_x = $urandom;
    r.point_y = $urandom;
    r.point_z = $urandom;
    return r;
  endfunction

  function automatic ptpd_pkg::in_t make_xform(logic signed [31:0] x, y, z);
    ptpd_pkg::in_t r;
    r.op = ptpd_pkg::OP_XFORM;
    r.elem_index = 4'($urandom);
    r.elem_value = $urandom;
    r.point_x = x;
    r.point_y = y;
    r.point_z = z;
    return r;
  endfunction

  task automatic drain();
    while (pending_req.size() > 0 || pt_valid || expected_pts.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tol_reg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15)
        pending_req.push_back(make_load($urandom_range(15), rand_q16()));
      else
        pending_req.push_back(make_xform(rand_q16(), rand_q16(), rand_q16()));
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
    tol_reg = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: identity, extremes, w exactly zero and one, projection, ignored fields
    pending_req.push_back(make_xform(32'sh0001_8000, -32'sh0002_0000, 32'sh0));
    pending_req.push_back(make_xform(32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF));
    pending_req.push_back(make_load(15, 32'sh0));
    pending_req.push_back(make_xform(32'sh0003_0000, 32'sh0001_0000, 32'sh0002_0000));
    pending_req.push_back(make_load(11, 32'sh0001_0000));
    pending_req.push_back(make_xform(32'sh0003_0000, 32'sh0001_0000, 32'sh0002_0000));
    pending_req.push_back(make_xform(32'sh0003_0000, 32'sh0001_0000, -32'sh0000_0001));
    pending_req.push_back(make_xform(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0001));
    pending_req.push_back(make_xform(32'sh0, 32'sh0, 32'sh0001_0000));
    pending_req.push_back(make_load(0, 32'sh7FFF_FFFF));
    pending_req.push_back(make_load(12, 32'sh8000_0000));
    pending_req.push_back(make_xform(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0100));
    pending_req.push_back(make_xform(32'sh8000_0000, 32'sh0, -32'sh0000_0100));
    drain();

    // Tolerance at its top, then small values
    write_tolerance(16'hFFFF);
    pending_req.push_back(make_xform(32'sh0001_0000, 32'sh0, 32'sh0001_0000));
    pending_req.push_back(make_xform(32'sh0001_0000, 32'sh0, 32'sh0000_8000));
    random_phase(250);
    drain();
    write_tolerance(16'h0100);

    send_idle_pct = 27; recv_idle_pct = 51;
    random_phase(500);
    drain();
    write_tolerance(16'h0001);

    // Long receiver hold while the sender keeps offering
    recv_hold_cycles = 150;
    send_idle_pct = 51; recv_idle_pct = 27;
    random_phase(500);
    repeat (300) @(posedge clk);
    // Sender pauses mid-stream until every expected result has arrived
    send_hold = 1;
    while (pt_valid || expected_pts.size() > 0) @(posedge clk);
    send_hold = 0;
    drain();
    write_tolerance(16'h0000);

    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(550);
    drain();

    $display("applied %0d loads and %0d transforms, checked %0d results",
             loads, accepted_pts - loads, checked_pts);
    $display("%0d with perspective divide, %0d saturated, %0d mismatches",
             divides, sats, mismatches);
    if (mismatches == 0 && expected_pts.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule

// ----- files.f -----
src/ptpd_pkg.sv
src/ptpd_mac.sv
src/ptpd_prep.sv
src/ptpd_div.sv
src/point_transform_perspective_divide_top.sv
sim/tb_top.sv
